// File: rtl/hcr_pkg.sv
// Shared types and constants of the Harris corner response unit.
// No dependencies; the front end, queue, back end, top level and testbench refer to it by scoped names.
package hcr_pkg;

	localparam int unsigned MAX_WIDTH = 1024;
	localparam int unsigned COL_W     = 10;
	localparam int unsigned ROW_W     = 12;
	localparam int unsigned CNT_ROW_W = 13;
	localparam int unsigned PIX_W     = 8;
	localparam int unsigned GRAD_W    = 11;
	localparam int unsigned RESP_W    = 46;
	localparam int unsigned K_W       = 15;
	localparam int unsigned CFG_W     = 15;
	localparam int unsigned IDX_W     = 2;
	localparam int unsigned WIN       = 3;

	localparam logic [10:0] MIN_WIDTH  = 11'd3;
	localparam logic [10:0] MAX_WIDTH_V = 11'd1024;
	localparam logic [12:0] MIN_HEIGHT = 13'd3;
	localparam logic [12:0] MAX_HEIGHT = 13'd4096;

	localparam logic [10:0] RST_WIDTH  = 11'd640;
	localparam logic [12:0] RST_HEIGHT = 13'd480;
	localparam logic [14:0] RST_K      = 15'd2621;

	localparam logic signed [49:0] RESP_MAX = 50'sd35184372088831;
	localparam logic signed [49:0] RESP_MIN = -50'sd35184372088832;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_K      = 2'd2
	} reg_idx_t;

	typedef enum logic {
		REQ_PIXEL = 1'b0,
		REQ_DRAIN = 1'b1
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_GRAD,
		ST_ACC,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_SAT
	} state_t;

	typedef struct packed {
		logic signed [GRAD_W-1:0] ix;
		logic signed [GRAD_W-1:0] iy;
	} gpair_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [COL_W-1:0] pix_col;
		logic [COL_W-1:0] grad_col;
		logic             grad_on;
		logic             grad_zero;
		logic             resp_on;
		logic             m_left;
		logic             m_right;
		logic             m_top;
		logic             m_bottom;
		logic [COL_W-1:0] resp_col;
		logic [ROW_W-1:0] resp_row;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

endpackage

// File: rtl/hcr_pix_if.sv
// Input channel: one beat carries a request type and a pixel.
// Depends on nothing.
interface hcr_pix_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] pixel;

	modport source(output valid, req_type, pixel, input ready);
	modport sink(input valid, req_type, pixel, output ready);
endinterface

// File: rtl/hcr_resp_if.sv
// Output channel: one beat carries a corner response and its position.
// Depends on nothing.
interface hcr_resp_if;
	logic               valid;
	logic               ready;
	logic signed [45:0] response;
	logic        [9:0]  out_col;
	logic        [11:0] out_row;
	logic               frame_end;

	modport source(output valid, response, out_col, out_row, frame_end, input ready);
	modport sink(input valid, response, out_col, out_row, frame_end, output ready);
endinterface

// File: rtl/harris_corner_response_unit.sv
// Harris corner response unit, top level: front end, command queue, back end.
// Depends on hcr_pkg, hcr_pix_if, hcr_resp_if, hcr_front, hcr_queue, hcr_back.
//
//  port      dir   beat fields
//  pix_in    sink  req_type, pixel
//  resp_out  src   response, out_col, out_row, frame_end
//  cfg_*     in    cfg_we, cfg_index, cfg_data (write only)
//
// The front end takes one beat per cycle while the command queue has room.
// The back end passes an item with no result through read and gradient steps;
// an item with a result also goes through the nine-element window sum, one
// element a cycle, then four multiply and saturate steps. The output register
// frees the back end as soon as a result is loaded. Reset clears control state
// only; line buffer contents are never read before written within a frame.
module harris_corner_response_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	hcr_pix_if.sink                   pix_in,
	hcr_resp_if.source                resp_out,
	input  logic                      cfg_we,
	input  logic [hcr_pkg::IDX_W-1:0] cfg_index,
	input  logic [hcr_pkg::CFG_W-1:0] cfg_data
);

	hcr_pkg::q_stat_t        q_stat;
	hcr_pkg::cmd_t           push_cmd, head_cmd;
	logic                    push, pop;
	logic [hcr_pkg::K_W-1:0] harris_k;

	hcr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_in   (pix_in),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd),
		.harris_k (harris_k)
	);

	hcr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head_cmd(head_cmd),
		.stat    (q_stat)
	);

	hcr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_stat  (q_stat),
		.head_cmd(head_cmd),
		.pop     (pop),
		.harris_k(harris_k),
		.resp_out(resp_out)
	);

endmodule

// File: rtl/hcr_front.sv
// Front end: configuration registers, frame position counters, item classification.
// Depends on hcr_pkg and hcr_pix_if.
module hcr_front (
	input  logic                           clk,
	input  logic                           arst_n,
	hcr_pix_if.sink                        pix_in,
	input  logic                           cfg_we,
	input  logic [hcr_pkg::IDX_W-1:0]      cfg_index,
	input  logic [hcr_pkg::CFG_W-1:0]      cfg_data,
	input  hcr_pkg::q_stat_t               q_stat,
	output logic                           push,
	output hcr_pkg::cmd_t                  push_cmd,
	output logic [hcr_pkg::K_W-1:0]        harris_k
);

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [14:0] k_q;

	logic [10:0] w_eff, w_m1;
	logic [12:0] h_eff, h_m1;
	logic [9:0]  w_last;
	logic [11:0] h_last;

	logic [9:0]  pc_q, gc_q, rc_q;
	logic [12:0] pr_q, gr_q;
	logic [11:0] rr_q;
	logic        g_on_q, r_on_q;

	logic accept, in_frame, bubble, step, g_on_now, r_on_now, last, restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= hcr_pkg::RST_WIDTH;
			height_q <= hcr_pkg::RST_HEIGHT;
			k_q      <= hcr_pkg::RST_K;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hcr_pkg::REG_WIDTH:  width_q  <= cfg_data[10:0];
				hcr_pkg::REG_HEIGHT: height_q <= cfg_data[12:0];
				hcr_pkg::REG_K:      k_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < hcr_pkg::MIN_WIDTH)
			w_eff = hcr_pkg::MIN_WIDTH;
		else if (width_q > hcr_pkg::MAX_WIDTH_V)
			w_eff = hcr_pkg::MAX_WIDTH_V;
		else
			w_eff = width_q;
		if (height_q < hcr_pkg::MIN_HEIGHT)
			h_eff = hcr_pkg::MIN_HEIGHT;
		else if (height_q > hcr_pkg::MAX_HEIGHT)
			h_eff = hcr_pkg::MAX_HEIGHT;
		else
			h_eff = height_q;
		w_m1   = w_eff - 11'd1;
		h_m1   = h_eff - 13'd1;
		w_last = w_m1[9:0];
		h_last = h_m1[11:0];
	end

	assign harris_k     = k_q;
	assign pix_in.ready = !q_stat.full;
	assign accept       = pix_in.valid && pix_in.ready;
	assign in_frame     = pr_q < h_eff;
	assign bubble       = (pix_in.req_type == hcr_pkg::REQ_DRAIN) && in_frame;
	assign step         = accept && !bubble;
	assign g_on_now     = g_on_q || (pc_q == 10'd1 && pr_q == 13'd1);
	assign r_on_now     = r_on_q || (g_on_now && gc_q == 10'd1 && gr_q == 13'd1);
	assign last         = r_on_now && rc_q == w_last && rr_q == h_last;
	assign restart      = cfg_we && (cfg_index == hcr_pkg::REG_WIDTH ||
		cfg_index == hcr_pkg::REG_HEIGHT);
	assign push         = step;

	always_comb begin
		push_cmd.pixel     = pix_in.pixel;
		push_cmd.pix_col   = pc_q;
		push_cmd.grad_col  = gc_q;
		push_cmd.grad_on   = g_on_now;
		push_cmd.grad_zero = gc_q == 10'd0 || gc_q == w_last || gr_q == 13'd0 ||
			gr_q >= {1'b0, h_last};
		push_cmd.resp_on   = r_on_now;
		push_cmd.m_left    = rc_q == 10'd0;
		push_cmd.m_right   = rc_q == w_last;
		push_cmd.m_top     = rr_q == 12'd0;
		push_cmd.m_bottom  = rr_q == h_last;
		push_cmd.resp_col  = rc_q;
		push_cmd.resp_row  = rr_q;
		push_cmd.last      = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0; pr_q <= '0; gc_q <= '0; gr_q <= '0; rc_q <= '0; rr_q <= '0;
			g_on_q <= 1'b0; r_on_q <= 1'b0;
		end else if (restart || (step && last)) begin
			pc_q <= '0; pr_q <= '0; gc_q <= '0; gr_q <= '0; rc_q <= '0; rr_q <= '0;
			g_on_q <= 1'b0; r_on_q <= 1'b0;
		end else if (step) begin
			if (pc_q == w_last) begin
				pc_q <= '0;
				pr_q <= pr_q + 13'd1;
			end else begin
				pc_q <= pc_q + 10'd1;
			end
			if (g_on_now) begin
				if (gc_q == w_last) begin
					gc_q <= '0;
					gr_q <= gr_q + 13'd1;
				end else begin
					gc_q <= gc_q + 10'd1;
				end
			end
			if (r_on_now) begin
				if (rc_q == w_last) begin
					rc_q <= '0;
					rr_q <= rr_q + 12'd1;
				end else begin
					rc_q <= rc_q + 10'd1;
				end
			end
			g_on_q <= g_on_now;
			r_on_q <= r_on_now;
		end
	end

endmodule

// File: rtl/hcr_queue.sv
// Command queue between the front end and the back end.
// Depends on hcr_pkg.
module hcr_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hcr_pkg::cmd_t    push_cmd,
	input  logic             pop,
	output hcr_pkg::cmd_t    head_cmd,
	output hcr_pkg::q_stat_t stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	hcr_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign stat.full     = cnt_q == CNT_FULL;
	assign stat.nonempty = cnt_q != '0;
	assign do_push       = push && !stat.full;
	assign do_pop        = pop && stat.nonempty;
	assign head_cmd      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
			if (do_pop)
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

// File: rtl/hcr_back.sv
// Back end: line buffers, Prewitt gradients, window sums and the response datapath.
// Depends on hcr_pkg and hcr_resp_if.
module hcr_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hcr_pkg::q_stat_t        q_stat,
	input  hcr_pkg::cmd_t           head_cmd,
	output logic                    pop,
	input  logic [hcr_pkg::K_W-1:0] harris_k,
	hcr_resp_if.source              resp_out
);

	hcr_pkg::state_t state_q, state_d;
	hcr_pkg::cmd_t   cmd_q;

	logic [7:0]      pix_top_mem [hcr_pkg::MAX_WIDTH];
	logic [7:0]      pix_mid_mem [hcr_pkg::MAX_WIDTH];
	hcr_pkg::gpair_t grad_top_mem [hcr_pkg::MAX_WIDTH];
	hcr_pkg::gpair_t grad_mid_mem [hcr_pkg::MAX_WIDTH];

	logic [7:0]      pt_rd_q, pm_rd_q;
	hcr_pkg::gpair_t gt_rd_q, gm_rd_q;

	logic [7:0]      pw_q [3][3];
	hcr_pkg::gpair_t gw_q [3][3];
	hcr_pkg::gpair_t g_new, elem;

	logic [1:0] ecol_q, erow_q;
	logic       masked, acc_done, can_load;

	logic signed [21:0] pxx, pyy, pxy;
	logic        [22:0] sxx_q, syy_q;
	logic signed [23:0] sxy_q;
	logic signed [47:0] sxy_sq;
	logic        [45:0] p1_q, p2_q;
	logic        [23:0] tr_q;
	logic signed [47:0] det_q, det2_q;
	logic        [47:0] t2_q;
	logic        [62:0] ktf_q;
	logic signed [49:0] r_full;
	logic signed [45:0] r_sat;

	logic               out_valid_q;
	logic signed [45:0] out_resp_q;
	logic        [9:0]  out_col_q;
	logic        [11:0] out_row_q;
	logic               out_end_q;

	assign pop      = (state_q == hcr_pkg::ST_IDLE) && q_stat.nonempty;
	assign can_load = !out_valid_q || resp_out.ready;
	assign acc_done = ecol_q == 2'd2 && erow_q == 2'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= hcr_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hcr_pkg::ST_IDLE: if (pop) state_d = hcr_pkg::ST_READ;
			hcr_pkg::ST_READ: state_d = hcr_pkg::ST_GRAD;
			hcr_pkg::ST_GRAD: state_d = cmd_q.resp_on ? hcr_pkg::ST_ACC : hcr_pkg::ST_IDLE;
			hcr_pkg::ST_ACC:  if (acc_done) state_d = hcr_pkg::ST_MUL1;
			hcr_pkg::ST_MUL1: state_d = hcr_pkg::ST_MUL2;
			hcr_pkg::ST_MUL2: state_d = hcr_pkg::ST_MUL3;
			hcr_pkg::ST_MUL3: state_d = hcr_pkg::ST_SAT;
			hcr_pkg::ST_SAT:  if (can_load) state_d = hcr_pkg::ST_IDLE;
			default:          state_d = hcr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q   <= head_cmd;
			pt_rd_q <= pix_top_mem[head_cmd.pix_col];
			pm_rd_q <= pix_mid_mem[head_cmd.pix_col];
			gt_rd_q <= grad_top_mem[head_cmd.grad_col];
			gm_rd_q <= grad_mid_mem[head_cmd.grad_col];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == hcr_pkg::ST_READ) begin
			pix_top_mem[cmd_q.pix_col] <= pm_rd_q;
			pix_mid_mem[cmd_q.pix_col] <= cmd_q.pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == hcr_pkg::ST_GRAD && cmd_q.grad_on) begin
			grad_top_mem[cmd_q.grad_col] <= gm_rd_q;
			grad_mid_mem[cmd_q.grad_col] <= g_new;
		end
	end

	always_comb begin
		g_new.ix = '0;
		g_new.iy = '0;
		if (!cmd_q.grad_zero) begin
			for (int i = 0; i < 3; i++) begin
				g_new.ix = g_new.ix + $signed({3'b000, pw_q[2][i]}) -
					$signed({3'b000, pw_q[0][i]});
				g_new.iy = g_new.iy + $signed({3'b000, pw_q[i][2]}) -
					$signed({3'b000, pw_q[i][0]});
			end
		end
	end

	// advance the pixel window on read, the gradient window on gradient
	always_ff @(posedge clk) begin
		if (state_q == hcr_pkg::ST_READ) begin
			pw_q[0]    <= pw_q[1];
			pw_q[1]    <= pw_q[2];
			pw_q[2][0] <= pt_rd_q;
			pw_q[2][1] <= pm_rd_q;
			pw_q[2][2] <= cmd_q.pixel;
		end
		if (state_q == hcr_pkg::ST_GRAD) begin
			gw_q[0]    <= gw_q[1];
			gw_q[1]    <= gw_q[2];
			gw_q[2][0] <= gt_rd_q;
			gw_q[2][1] <= gm_rd_q;
			gw_q[2][2] <= g_new;
		end
	end

	always_comb begin
		elem   = gw_q[ecol_q][erow_q];
		masked = (ecol_q == 2'd0 && cmd_q.m_left) || (ecol_q == 2'd2 && cmd_q.m_right) ||
			(erow_q == 2'd0 && cmd_q.m_top) || (erow_q == 2'd2 && cmd_q.m_bottom);
		pxx    = 22'(elem.ix) * 22'(elem.ix);
		pyy    = 22'(elem.iy) * 22'(elem.iy);
		pxy    = 22'(elem.ix) * 22'(elem.iy);
		sxy_sq = 48'(sxy_q) * 48'(sxy_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecol_q <= '0;
			erow_q <= '0;
		end else if (state_q == hcr_pkg::ST_GRAD) begin
			ecol_q <= '0;
			erow_q <= '0;
		end else if (state_q == hcr_pkg::ST_ACC) begin
			if (erow_q == 2'd2) begin
				erow_q <= '0;
				ecol_q <= ecol_q + 2'd1;
			end else begin
				erow_q <= erow_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			hcr_pkg::ST_GRAD: begin
				sxx_q <= '0;
				syy_q <= '0;
				sxy_q <= '0;
			end
			hcr_pkg::ST_ACC: begin
				if (!masked) begin
					sxx_q <= sxx_q + {2'b00, pxx[20:0]};
					syy_q <= syy_q + {2'b00, pyy[20:0]};
					sxy_q <= sxy_q + 24'(pxy);
				end
			end
			hcr_pkg::ST_MUL1: begin
				p1_q <= 46'(sxx_q) * 46'(syy_q);
				p2_q <= sxy_sq[45:0];
				tr_q <= {1'b0, sxx_q} + {1'b0, syy_q};
			end
			hcr_pkg::ST_MUL2: begin
				det_q <= $signed({2'b00, p1_q}) - $signed({2'b00, p2_q});
				t2_q  <= 48'(tr_q) * 48'(tr_q);
			end
			hcr_pkg::ST_MUL3: begin
				det2_q <= det_q;
				ktf_q  <= 63'(t2_q) * 63'(harris_k);
			end
			default: ;
		endcase
	end

	always_comb begin
		r_full = {{2{det2_q[47]}}, det2_q} - $signed({3'b000, ktf_q[62:16]});
		if (r_full > hcr_pkg::RESP_MAX)
			r_sat = hcr_pkg::RESP_MAX[45:0];
		else if (r_full < hcr_pkg::RESP_MIN)
			r_sat = hcr_pkg::RESP_MIN[45:0];
		else
			r_sat = r_full[45:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == hcr_pkg::ST_SAT && can_load)
			out_valid_q <= 1'b1;
		else if (resp_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == hcr_pkg::ST_SAT && can_load) begin
			out_resp_q <= r_sat;
			out_col_q  <= cmd_q.resp_col;
			out_row_q  <= cmd_q.resp_row;
			out_end_q  <= cmd_q.last;
		end
	end

	assign resp_out.valid     = out_valid_q;
	assign resp_out.response  = out_resp_q;
	assign resp_out.out_col   = out_col_q;
	assign resp_out.out_row   = out_row_q;
	assign resp_out.frame_end = out_end_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == hcr_pkg::ST_IDLE)
		else $error("command taken outside idle");

	a_acc_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hcr_pkg::ST_ACC && acc_done) |=> state_q == hcr_pkg::ST_MUL1)
		else $error("window sum did not finish after nine elements");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hcr_pkg::ST_SAT && can_load) |=>
		(out_valid_q && state_q == hcr_pkg::ST_IDLE))
		else $error("result not loaded into output register");

	a_no_resp_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hcr_pkg::ST_GRAD && !cmd_q.resp_on) |=> state_q == hcr_pkg::ST_IDLE)
		else $error("item without response entered the sum path");

endmodule

// File: dv/tb_harris_corner_response_unit.sv
// Testbench for harris_corner_response_unit: drives pixel and drain beats,
// predicts each corner response or takes it from a fixed table, and checks every result beat in order.
// Depends on hcr_pkg, hcr_pix_if, hcr_resp_if and the unit itself.
`timescale 1ns / 1ps

module tb_harris_corner_response_unit;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE = 120;
	localparam int ITEM_GOAL = 1150;

	typedef struct {
		logic signed [45:0] response;
		logic [9:0]         col;
		logic [11:0]        row;
		logic               fend;
	} corner_t;

	typedef struct {
		hcr_pkg::req_t kind;
		logic [7:0]    pix;
		bit            known;
		corner_t       res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [14:0] cfg_data;

	hcr_pix_if pix();
	hcr_resp_if rsp();

	harris_corner_response_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pix_in(pix),
		.resp_out(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	logic [7:0] line_pix[3][1024];
	int line_gx[3][1024];
	int line_gy[3][1024];
	int unsigned frame_pos;
	int unsigned width_reg;
	int unsigned height_reg;
	int unsigned k_reg;

	corner_t corner_q[$];
	bit failed = 0;
	bit idle_on = 1;
	int items = 0;
	int stall_left = 0;

	function automatic int unsigned eff_w();
		if (width_reg < 3) return 3;
		if (width_reg > 1024) return 1024;
		return width_reg;
	endfunction

	function automatic int unsigned eff_h();
		if (height_reg < 3) return 3;
		if (height_reg > 4096) return 4096;
		return height_reg;
	endfunction

	function automatic void build_gradient(int unsigned g, int unsigned w, int unsigned h);
		int unsigned x, y, ra, rb, rc;
		int gx, gy;
		x = g % w;
		y = g / w;
		gx = 0;
		gy = 0;
		if (x >= 1 && x + 2 <= w && y >= 1 && y + 2 <= h) begin
			ra = (y - 1) % 3;
			rb = y % 3;
			rc = (y + 1) % 3;
			for (int d = -1; d <= 1; d++) begin
				gy += int'(line_pix[rc][x + d]) - int'(line_pix[ra][x + d]);
			end
			gx += int'(line_pix[ra][x + 1]) - int'(line_pix[ra][x - 1]);
			gx += int'(line_pix[rb][x + 1]) - int'(line_pix[rb][x - 1]);
			gx += int'(line_pix[rc][x + 1]) - int'(line_pix[rc][x - 1]);
		end
		line_gx[y % 3][x] = gx;
		line_gy[y % 3][x] = gy;
	endfunction

	function automatic longint corner_strength(int unsigned x, int unsigned y,
			int unsigned w, int unsigned h);
		longint sxx, syy, sxy, det, r, ix, iy;
		longint unsigned tr, kt;
		int yy, xx;
		sxx = 0;
		syy = 0;
		sxy = 0;
		for (int dy = -1; dy <= 1; dy++) begin
			yy = int'(y) + dy;
			if (yy < 0 || yy > int'(h) - 1) continue;
			for (int dx = -1; dx <= 1; dx++) begin
				xx = int'(x) + dx;
				if (xx < 0 || xx > int'(w) - 1) continue;
				ix = line_gx[yy % 3][xx];
				iy = line_gy[yy % 3][xx];
				sxx += ix * ix;
				syy += iy * iy;
				sxy += ix * iy;
			end
		end
		det = sxx * syy - sxy * sxy;
		tr = longint'(sxx + syy);
		kt = (tr * tr * longint'(k_reg)) >> 16;
		r = det - longint'(kt);
		if (r > 64'sd35184372088831) r = 64'sd35184372088831;
		if (r < -64'sd35184372088832) r = -64'sd35184372088832;
		return r;
	endfunction

	function automatic void predict_corner(input logic drain, input logic [7:0] px,
			output bit got, output corner_t res);
		int unsigned w, h, total, lag, q, p;
		bit last;
		w = eff_w();
		h = eff_h();
		total = w * h;
		lag = w + 1;
		q = frame_pos;
		got = 0;
		res = '{0, 0, 0, 0};
		if (drain && q < total) return;
		if (q < total) line_pix[(q / w) % 3][q % w] = px;
		if (q >= lag && q - lag < total) build_gradient(q - lag, w, h);
		if (q >= 2 * lag && q - 2 * lag < total) begin
			p = q - 2 * lag;
			last = (p == total - 1);
			res.response = 46'(corner_strength(p % w, p / w, w, h));
			res.col = 10'(p % w);
			res.row = 12'(p / w);
			res.fend = last;
			got = 1;
			frame_pos = last ? 0 : q + 1;
			return;
		end
		frame_pos = q + 1;
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [14:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == hcr_pkg::REG_WIDTH) begin
			width_reg = 32'(val & 15'h7FF);
			frame_pos = 0;
		end else if (idx == hcr_pkg::REG_HEIGHT) begin
			height_reg = 32'(val & 15'h1FFF);
			frame_pos = 0;
		end else if (idx == hcr_pkg::REG_K) begin
			k_reg = 32'(val);
		end
	endtask

	task automatic send_beat(hcr_pkg::req_t kind, logic [7:0] px, bit known, corner_t kres);
		bit got;
		corner_t res;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			pix.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.req_type <= kind;
		pix.pixel <= px;
		do @(posedge clk); while (!pix.ready);
		predict_corner(kind == hcr_pkg::REQ_DRAIN, px, got, res);
		if (got) corner_q.push_back(known ? kres : res);
	endtask

	task automatic wait_drained();
		pix.valid <= 1'b0;
		while (corner_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_frame(int mode, bit partial);
		int unsigned w, h, total, count;
		logic [7:0] px;
		corner_t none;
		none = '{0, 0, 0, 0};
		w = eff_w();
		h = eff_h();
		total = w * h;
		count = partial ? $urandom_range(1, total - 1) : total;
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(0, 30) == 0)
				send_beat(hcr_pkg::REQ_DRAIN, 8'($urandom), 0, none);
			case (mode)
				0: px = 8'($urandom);
				1: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				2: px = (((i % w) >= w / 2) ^ ((i / w) >= h / 2)) ? 8'hFF : 8'h00;
				default: px = 8'(100 + $urandom_range(0, 7));
			endcase
			send_beat(hcr_pkg::REQ_PIXEL, px, 0, none);
			items++;
		end
		if (!partial) begin
			for (int unsigned i = 0; i < 2 * (w + 1); i++) begin
				if ($urandom_range(0, 5) == 0)
					send_beat(hcr_pkg::REQ_PIXEL, 8'($urandom), 0, none);
				else
					send_beat(hcr_pkg::REQ_DRAIN, 8'($urandom), 0, none);
				items++;
			end
		end
		wait_drained();
	endtask

	stim_row_t flat_frame[19] = '{
		'{hcr_pkg::REQ_DRAIN, 8'h00, 0, '{0, 0, 0, 0}},
		'{hcr_pkg::REQ_PIXEL, 8'hFF, 0, '{0, 0, 0, 0}},
		'{hcr_pkg::REQ_PIXEL, 8'hFF, 0, '{0, 0, 0, 0}},
		'{hcr_pkg::REQ_PIXEL, 8'hFF, 0, '{0, 0, 0, 0}},
		'{hcr_pkg::REQ_PIXEL, 8'hFF, 0, '{0, 0, 0, 0}},
		'{hcr_pkg::REQ_PIXEL, 8'hFF, 0, '{0, 0, 0, 0}},
		'{hcr_pkg::REQ_PIXEL, 8'hFF, 0, '{0, 0, 0, 0}},
		'{hcr_pkg::REQ_PIXEL, 8'hFF, 0, '{0, 0, 0, 0}},
		'{hcr_pkg::REQ_PIXEL, 8'hFF, 0, '{0, 0, 0, 0}},
		'{hcr_pkg::REQ_PIXEL, 8'hFF, 1, '{0, 0, 0, 0}},
		'{hcr_pkg::REQ_DRAIN, 8'h00, 1, '{0, 1, 0, 0}},
		'{hcr_pkg::REQ_DRAIN, 8'h00, 1, '{0, 2, 0, 0}},
		'{hcr_pkg::REQ_DRAIN, 8'h00, 1, '{0, 0, 1, 0}},
		'{hcr_pkg::REQ_DRAIN, 8'h00, 1, '{0, 1, 1, 0}},
		'{hcr_pkg::REQ_DRAIN, 8'h00, 1, '{0, 2, 1, 0}},
		'{hcr_pkg::REQ_DRAIN, 8'h00, 1, '{0, 0, 2, 0}},
		'{hcr_pkg::REQ_DRAIN, 8'h00, 1, '{0, 1, 2, 0}},
		'{hcr_pkg::REQ_PIXEL, 8'h00, 1, '{0, 2, 2, 1}},
		'{hcr_pkg::REQ_DRAIN, 8'h00, 0, '{0, 0, 0, 0}}
	};

	always @(posedge clk) begin
		corner_t want;
		if (rsp.valid && rsp.ready) begin
			if (corner_q.size() == 0) begin
				$error("response beat with nothing expected: col %0d row %0d",
					rsp.out_col, rsp.out_row);
				failed = 1;
			end else begin
				want = corner_q.pop_front();
				if (rsp.response !== want.response) begin
					$error("response: expected %0d, got %0d", want.response, rsp.response);
					failed = 1;
				end
				if (rsp.out_col !== want.col) begin
					$error("out_col: expected %0d, got %0d", want.col, rsp.out_col);
					failed = 1;
				end
				if (rsp.out_row !== want.row) begin
					$error("out_row: expected %0d, got %0d", want.row, rsp.out_row);
					failed = 1;
				end
				if (rsp.frame_end !== want.fend) begin
					$error("frame_end: expected %0b, got %0b", want.fend, rsp.frame_end);
					failed = 1;
				end
			end
		end
		if (!arst_n) begin
			rsp.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp.ready <= (stall_left == 1);
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(1, 8);
			rsp.ready <= 1'b0;
		end
	end

	initial begin
		#4_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		cfg_we = 1'b0;
		cfg_index = hcr_pkg::REG_WIDTH;
		cfg_data = '0;
		pix.valid = 1'b0;
		pix.req_type = hcr_pkg::REQ_PIXEL;
		pix.pixel = '0;
		width_reg = 640;
		height_reg = 480;
		k_reg = 2621;
		frame_pos = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_UNUSED, 15'($urandom));
		write_reg(hcr_pkg::REG_WIDTH, 15'd3);
		write_reg(hcr_pkg::REG_HEIGHT, 15'd3);
		foreach (flat_frame[i])
			send_beat(flat_frame[i].kind, flat_frame[i].pix, flat_frame[i].known,
				flat_frame[i].res);
		wait_drained();

		write_reg(hcr_pkg::REG_K, 15'd0);
		write_reg(hcr_pkg::REG_WIDTH, 15'd4);
		write_reg(hcr_pkg::REG_HEIGHT, 15'd4);
		run_frame(2, 0);
		write_reg(hcr_pkg::REG_K, 15'd32767);
		run_frame(1, 0);
		write_reg(hcr_pkg::REG_K, 15'd16384);
		run_frame(0, 1);
		write_reg(hcr_pkg::REG_HEIGHT, 15'd5);
		run_frame(0, 0);

		while (items < ITEM_GOAL) begin
			if (items > ITEM_GOAL * 85 / 100) idle_on = 0;
			if ($urandom_range(0, 5) == 0) write_reg(hcr_pkg::REG_K, 15'($urandom));
			write_reg(hcr_pkg::REG_WIDTH, 15'($urandom_range(3, 12)));
			write_reg(hcr_pkg::REG_HEIGHT, 15'($urandom_range(3, 8)));
			run_frame($urandom_range(0, 3), $urandom_range(0, 7) == 0);
		end

		idle_on = 0;
		write_reg(hcr_pkg::REG_K, 15'd32767);
		write_reg(hcr_pkg::REG_WIDTH, 15'h0800);
		write_reg(hcr_pkg::REG_HEIGHT, 15'd1);
		run_frame(2, 0);
		write_reg(hcr_pkg::REG_K, 15'($urandom));
		write_reg(hcr_pkg::REG_WIDTH, 15'h7804);
		write_reg(hcr_pkg::REG_HEIGHT, 15'h6005);
		run_frame(0, 0);

		if (!failed) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/hcr_pkg.sv
rtl/hcr_pix_if.sv
rtl/hcr_resp_if.sv
rtl/hcr_front.sv
rtl/hcr_queue.sv
rtl/hcr_back.sv
rtl/harris_corner_response_unit.sv
dv/tb_harris_corner_response_unit.sv
